### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### hw/rtl/cfc_pkg.sv
// Types and constants for the chunk box frustum cull block.
package cfc_pkg;
	localparam int IN_W      = 12;
	localparam int FIX_W     = 32;
	localparam int PAIR_W    = 64;
	localparam int NUM_PAIRS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CORNERS = 8;

	typedef struct packed {
		logic signed [IN_W-1:0]  chunk_x;
		logic signed [IN_W-1:0]  chunk_y;
		logic signed [IN_W-1:0]  chunk_z;
		logic signed [FIX_W-1:0] eye_x;
		logic signed [FIX_W-1:0] eye_y;
		logic signed [FIX_W-1:0] eye_z;
	} in_item_t;

	typedef struct packed {
		logic       visible;
		logic [1:0] cull_cause;
	} out_item_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_RANGE   = 2'd1,
		CAUSE_FRUSTUM = 2'd2
	} cull_cause_t;

	typedef struct packed {
		logic left_out;
		logic right_out;
		logic bottom_out;
		logic top_out;
		logic near_out;
		logic far_out;
	} plane_flags_t;
endpackage

### hw/rtl/cfc_plane_check.sv
// Clip-plane classification of one transformed corner.
module cfc_plane_check #(
	parameter int CLIP_W = 57
) (
	input  logic signed [CLIP_W-1:0] clip_x,
	input  logic signed [CLIP_W-1:0] clip_y,
	input  logic signed [CLIP_W-1:0] clip_z,
	input  logic signed [CLIP_W-1:0] clip_w,
	output cfc_pkg::plane_flags_t    outside
);
	import cfc_pkg::*;

	logic signed [CLIP_W:0] ex, ey, ez, ew, neg_w;
	logic                   w_pos;

	always_comb begin
		ex    = (CLIP_W+1)'(clip_x);
		ey    = (CLIP_W+1)'(clip_y);
		ez    = (CLIP_W+1)'(clip_z);
		ew    = (CLIP_W+1)'(clip_w);
		neg_w = -ew;
		w_pos = (ew > 0);
		outside.left_out   = w_pos && (ex < neg_w);
		outside.right_out  = w_pos && (ex > ew);
		outside.bottom_out = w_pos && (ey < neg_w);
		outside.top_out    = w_pos && (ey > ew);
		outside.near_out   = !w_pos || (ez < neg_w);
		outside.far_out    = w_pos && (ez > ew);
	end
endmodule

### hw/rtl/chunk_box_frustum_cull.sv
// Top level: render-range and view-frustum test of chunk boxes, five-stage pipeline.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data               | chunk coordinate and eye
//  out     | out_valid, out_ready, out_data            | visible flag and cull cause
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one matrix pair register
//
// One transaction per cycle when nothing stalls; each input passes through stage
// registers s1 to s5 before out_valid rises.
// Stages: offsets and range deltas, multipliers, sums, corner clip values,
// plane compares into the output register.
// Reset clears all valid bits and the matrix registers; no clearing pass.
// Each stage holds while the one after it is full and stalled; cfg is always ready.
`include "assert_macros.svh"
module chunk_box_frustum_cull #(
	parameter int BOX_WIDTH       = 16,
	parameter int BOX_HEIGHT      = 16,
	parameter int BOX_LENGTH      = 16,
	parameter int RANGE_IN_CHUNKS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cfc_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cfc_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfc_pkg::PAIR_W-1:0]          cfg_data
);
	import cfc_pkg::*;

	localparam int BMAX_A  = (BOX_WIDTH > BOX_HEIGHT) ? BOX_WIDTH : BOX_HEIGHT;
	localparam int BMAX    = (BMAX_A > BOX_LENGTH) ? BMAX_A : BOX_LENGTH;
	localparam int CW      = IN_W + $clog2(BMAX + 1) + 1;
	localparam int PW      = FIX_W + CW;
	localparam int CLIP_W  = PW + 3;
	localparam int DW      = CW + 17;
	localparam longint RANGE_Q = longint'(RANGE_IN_CHUNKS) * longint'(BOX_WIDTH) * 65536;
	localparam int AW      = $clog2(RANGE_Q + 1);
	localparam int SW      = 2 * AW + 2;
	localparam logic [SW-1:0] RANGE_SQ = SW'(RANGE_Q) * SW'(RANGE_Q);
	localparam longint HALF_X = longint'(BOX_WIDTH) * 32768;
	localparam longint HALF_Y = longint'(BOX_HEIGHT) * 32768;
	localparam longint HALF_Z = longint'(BOX_LENGTH) * 32768;

	logic [PAIR_W-1:0] pair_q [NUM_PAIRS];
	logic signed [FIX_W-1:0] m [4][4];
	logic signed [CW-1:0] bsz [3];

	logic en1, en2, en3, en4, en5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CW-1:0] lo_c [3];
	logic signed [DW-1:0] d_c [3];
	logic [DW-1:0]        ad_c [3];
	logic                 far_c;

	logic signed [CW-1:0] lo_s1 [3];
	logic [AW-1:0]        mag_s1 [3];
	logic                 far_s1;

	logic [2*AW-1:0]      sq_s2 [3];
	logic signed [PW-1:0] prod_s2 [4][3];
	logic signed [PW-1:0] del_s2 [4][3];
	logic signed [FIX_W-1:0] m3_s2 [4];
	logic                 far_s2;

	logic signed [CLIP_W-1:0] base_s3 [4];
	logic signed [PW-1:0]     del_s3 [4][3];
	logic                     far_s3;
	logic [SW-1:0]            sum_sq;

	logic signed [CLIP_W-1:0] clip_s4 [NUM_CORNERS][4];
	logic                     far_s4;

	plane_flags_t flags [NUM_CORNERS];
	plane_flags_t all_out;
	out_item_t    res_c;
	out_item_t    out_s5;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAIRS; i++) pair_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pair_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = pair_q[(r << 1) | (c >> 1)][FIX_W*(c & 1) +: FIX_W];
			end
		end
		bsz[0] = CW'(BOX_WIDTH);
		bsz[1] = CW'(BOX_HEIGHT);
		bsz[2] = CW'(BOX_LENGTH);
	end

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		lo_c[0] = CW'(in_data.chunk_x * BOX_WIDTH);
		lo_c[1] = CW'(in_data.chunk_y * BOX_HEIGHT);
		lo_c[2] = CW'(in_data.chunk_z * BOX_LENGTH);
		d_c[0] = (DW'(lo_c[0]) <<< 16) + DW'(HALF_X) - DW'(in_data.eye_x);
		d_c[1] = (DW'(lo_c[1]) <<< 16) + DW'(HALF_Y) - DW'(in_data.eye_y);
		d_c[2] = (DW'(lo_c[2]) <<< 16) + DW'(HALF_Z) - DW'(in_data.eye_z);
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			ad_c[i] = d_c[i][DW-1] ? DW'(-d_c[i]) : DW'(d_c[i]);
			if (ad_c[i] > DW'(RANGE_Q)) far_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				lo_s1[i]  <= lo_c[i];
				mag_s1[i] <= ad_c[i][AW-1:0];
			end
			far_s1 <= far_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= {AW'(0), mag_s1[i]} * {AW'(0), mag_s1[i]};
			end
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= PW'(m[r][c]) * PW'(lo_s1[c]);
					del_s2[r][c]  <= PW'(m[r][c]) * PW'(bsz[c]);
				end
				m3_s2[r] <= m[r][3];
			end
			far_s2 <= far_s1;
		end
	end

	assign sum_sq = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			for (int r = 0; r < 4; r++) begin
				base_s3[r] <= CLIP_W'(prod_s2[r][0]) + CLIP_W'(prod_s2[r][1])
					+ CLIP_W'(prod_s2[r][2]) + CLIP_W'(m3_s2[r]);
				for (int c = 0; c < 3; c++) del_s3[r][c] <= del_s2[r][c];
			end
			far_s3 <= far_s2 || (sum_sq > RANGE_SQ);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				for (int r = 0; r < 4; r++) begin
					clip_s4[k][r] <= base_s3[r]
						+ (((k & 1) != 0) ? CLIP_W'(del_s3[r][0]) : CLIP_W'(0))
						+ (((k & 2) != 0) ? CLIP_W'(del_s3[r][1]) : CLIP_W'(0))
						+ (((k & 4) != 0) ? CLIP_W'(del_s3[r][2]) : CLIP_W'(0));
				end
			end
			far_s4 <= far_s3;
		end
	end

	for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
		cfc_plane_check #(
			.CLIP_W (CLIP_W)
		) u_plane (
			.clip_x  (clip_s4[k][0]),
			.clip_y  (clip_s4[k][1]),
			.clip_z  (clip_s4[k][2]),
			.clip_w  (clip_s4[k][3]),
			.outside (flags[k])
		);
	end

	always_comb begin
		all_out = '1;
		for (int k = 0; k < NUM_CORNERS; k++) all_out = all_out & flags[k];
		if (far_s4) begin
			res_c.visible    = 1'b0;
			res_c.cull_cause = CAUSE_RANGE;
		end else if (|all_out) begin
			res_c.visible    = 1'b0;
			res_c.cull_cause = CAUSE_FRUSTUM;
		end else begin
			res_c.visible    = 1'b1;
			res_c.cull_cause = CAUSE_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) out_s5 <= res_c;
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

	`ASSERT_PROP(a_accept_fills_s1, clk, arst_n, in_valid && in_ready |=> v_s1)
	`ASSERT_PROP(a_s4_holds_on_stall, clk, arst_n, v_s4 && !en5 |=> v_s4)
	`ASSERT_PROP(a_cause_vs_visible, clk, arst_n, out_valid |-> (out_data.visible ^ (|out_data.cull_cause)))
	`ASSERT_NEVER(a_no_ready_when_full, clk, arst_n, in_ready && v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready)
endmodule
